### src/vbm_pkg.sv
// vbm_pkg: constants, types and codes for the 3d box mean filter
// used by every file of the block but vbm_ram, no dependencies

package vbm_pkg;

  localparam int MAX_X      = 128;
  localparam int MAX_Y      = 128;
  localparam int MAX_Z      = 4096;
  localparam int MAX_HW     = 2;
  localparam int PIXEL_BITS = 16;

  localparam int X_W   = $clog2(MAX_X);
  localparam int Y_W   = $clog2(MAX_Y);
  localparam int Z_W   = $clog2(MAX_Z);
  localparam int SX_W  = X_W + 1;
  localparam int SY_W  = Y_W + 1;
  localparam int SZ_W  = Z_W + 1;
  localparam int HW_W  = $clog2(MAX_HW + 1);
  localparam int SXY_W = X_W + Y_W + 1;
  localparam int LIN_W = X_W + Y_W + Z_W;
  localparam int TOT_W = LIN_W + 1;
  localparam int LAG_W = SXY_W + HW_W;

  localparam int STORE_DEPTH = (2 * MAX_HW + 1) * MAX_X * MAX_Y;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int OFF_W       = ADDR_W + 1;

  localparam int CUBE_N = (2 * MAX_HW + 1) * (2 * MAX_HW + 1) * (2 * MAX_HW + 1);
  localparam int N_W    = $clog2(CUBE_N + 1);
  localparam int SUM_W  = PIXEL_BITS + N_W;

  localparam int CFG_W     = SZ_W;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS  = 5;

  localparam int RST_HW = 1;
  localparam int RST_SX = 128;
  localparam int RST_SY = 128;
  localparam int RST_SZ = 128;

  localparam logic REQ_VOXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_SIZE_X      = 3'd1,
    REG_SIZE_Y      = 3'd2,
    REG_SIZE_Z      = 3'd3,
    REG_BINARY_MODE = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_OFFS,
    S_READ,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [SUM_W-1:0] quot;
    logic [N_W-1:0]   rem;
  } div_res_t;

endpackage

### src/vbm_in_if.sv
// vbm_in_if: input channel, valid/ready with request type and voxel value
// depends on vbm_pkg

interface vbm_in_if;
  import vbm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output req_type, output pixel_value, input ready);
  modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface

### src/vbm_out_if.sv
// vbm_out_if: result channel, valid/ready with filtered voxel and end flag
// depends on vbm_pkg

interface vbm_out_if;
  import vbm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  last_voxel;

  modport source (output valid, output pixel_out, output last_voxel, input ready);
  modport sink (input valid, input pixel_out, input last_voxel, output ready);
endinterface

### src/vbm_ram.sv
// vbm_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module vbm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### src/vbm_div.sv
// vbm_div: restoring divider, one quotient bit per cycle
// depends on vbm_pkg

module vbm_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [vbm_pkg::SUM_W-1:0] dividend,
  input  logic [vbm_pkg::N_W-1:0]   divisor,
  output logic                    done,
  output vbm_pkg::div_res_t       res
);
  import vbm_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] dq;
  logic [N_W-1:0]   rem;
  logic [N_W-1:0]   dv;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [N_W:0]     rem_sh;
  logic             ge;
  logic [N_W:0]     rem_nx;

  assign rem_sh = {rem, dq[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dv};
  assign rem_nx = ge ? rem_sh - {1'b0, dv} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq   <= dividend;
        rem  <= '0;
        dv   <= divisor;
        cnt  <= CNT_W'(SUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        dq  <= {dq[SUM_W-2:0], ge};
        rem <= rem_nx[N_W-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.quot = dq;
  assign res.rem  = rem;
endmodule

### src/volume_box_mean_filter.sv
// volume_box_mean_filter: 3d box mean / majority filter over a raster voxel stream
// depends on vbm_pkg, vbm_in_if, vbm_out_if, vbm_ram, vbm_div
//
//   channel  dir  payload                 transfer
//   in_ch    in   req_type, pixel_value   valid && ready
//   out_ch   out  pixel_out, last_voxel   valid && ready
//   cfg      in   cfg_index, cfg_data     cfg_we
//
// one item at a time; an item with no result is taken without leaving S_IDLE
// an item with a result walks the clipped cube of up to 125 voxels through the plane ram
// read port, then goes through the divider in mean mode
// ready stays low after reset and after a register write while sizes settle
// a finished result waits in the output register; the next item is taken meanwhile

module volume_box_mean_filter (
  input  logic                          clk,
  input  logic                          rst,
  vbm_in_if.sink                        in_ch,
  vbm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [vbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vbm_pkg::CFG_W-1:0]     cfg_data
);
  import vbm_pkg::*;

  // configuration
  logic [HW_W-1:0] hw_r;
  logic [SX_W-1:0] sx_r;
  logic [SY_W-1:0] sy_r;
  logic [SZ_W-1:0] sz_r;
  logic            bin_r;
  logic [HW_W-1:0] hw_c;
  logic [SX_W-1:0] sx_c;
  logic [SY_W-1:0] sy_c;
  logic [SZ_W-1:0] sz_c;
  logic [SXY_W-1:0] sxsy;
  logic [TOT_W-1:0] total;
  logic [LAG_W-1:0] lag;
  logic [SX_W+SY_W-1:0]    sxy_full;
  logic [SXY_W+SZ_W-1:0]   tot_full;
  logic [SXY_W-1:0]        lag_base;
  logic [LAG_W+HW_W-1:0]   lag_full;
  logic [1:0]      cfg_wait;
  logic            cfg_hit;

  // stream position
  logic [X_W-1:0]    in_x;
  logic [Y_W-1:0]    in_y;
  logic [Z_W-1:0]    in_z;
  logic [LIN_W-1:0]  in_lin;
  logic [ADDR_W-1:0] wr_addr;
  logic              all_in;
  logic [LIN_W-1:0]  out_index;
  logic [X_W-1:0]    cx;
  logic [Y_W-1:0]    cy;
  logic [Z_W-1:0]    cz;
  logic [ADDR_W-1:0] cmod;

  // cube walk
  state_t state, state_next;
  logic [X_W-1:0] xb, xe, ix;
  logic [Y_W-1:0] yb, ye, iy;
  logic [Z_W-1:0] zb, ze, iz;
  logic [OFF_W-1:0] off, row_off, plane_off;
  logic [OFF_W-1:0] mz, my, off0;
  logic [X_W-1:0] dx;
  logic [Y_W-1:0] dy;
  logic [Z_W-1:0] dz;
  logic issue_done;
  logic rd_vld, rd_ctr;
  logic [SUM_W-1:0] sum;
  logic [N_W-1:0]   n_cnt;
  logic [N_W-1:0]   nz_cnt;
  logic             ctr_nz;
  logic [ADDR_W+1:0] addr_sum;
  logic [ADDR_W+1:0] addr_fix;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;

  // handshake and results
  logic in_xfer, is_voxel, emit, out_free, last_out, rd_en, wr_en, div_start, div_done;
  logic [SX_W-1:0] cx_p;
  logic [SY_W-1:0] cy_p;
  logic [SZ_W-1:0] cz_p;
  div_res_t div_res;
  logic [SUM_W-1:0] q_rnd;
  logic [N_W:0]     r2;
  logic [PIXEL_BITS-1:0] res;
  logic                  vote;
  logic                  out_vld;
  logic [PIXEL_BITS-1:0] out_pix;
  logic                  out_last;

  assign cfg_hit = cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      hw_r  <= HW_W'(RST_HW);
      sx_r  <= SX_W'(RST_SX);
      sy_r  <= SY_W'(RST_SY);
      sz_r  <= SZ_W'(RST_SZ);
      bin_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_WIDTH:  hw_r  <= cfg_data[HW_W-1:0];
        REG_SIZE_X:      sx_r  <= cfg_data[SX_W-1:0];
        REG_SIZE_Y:      sy_r  <= cfg_data[SY_W-1:0];
        REG_SIZE_Z:      sz_r  <= cfg_data[SZ_W-1:0];
        REG_BINARY_MODE: bin_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sxy_full = {{SY_W{1'b0}}, sx_c} * {{SX_W{1'b0}}, sy_c};
  assign tot_full = {{SZ_W{1'b0}}, sxsy} * {{SXY_W{1'b0}}, sz_c};
  assign lag_base = sxsy + SXY_W'(sx_c) + SXY_W'(1);
  assign lag_full = {{LAG_W{1'b0}}, hw_c} * {{(HW_W*2){1'b0}}, lag_base};

  // clamp, then products, each registered: clamped sizes, then sxsy, then total and lag
  always_ff @(posedge clk) begin
    hw_c <= (hw_r == '0) ? HW_W'(1) : ((hw_r > HW_W'(MAX_HW)) ? HW_W'(MAX_HW) : hw_r);
    sx_c <= (sx_r == '0) ? SX_W'(1) : ((sx_r > SX_W'(MAX_X)) ? SX_W'(MAX_X) : sx_r);
    sy_c <= (sy_r == '0) ? SY_W'(1) : ((sy_r > SY_W'(MAX_Y)) ? SY_W'(MAX_Y) : sy_r);
    sz_c <= (sz_r == '0) ? SZ_W'(1) : ((sz_r > SZ_W'(MAX_Z)) ? SZ_W'(MAX_Z) : sz_r);
    sxsy  <= sxy_full[SXY_W-1:0];
    total <= tot_full[TOT_W-1:0];
    lag   <= lag_full[LAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      cfg_wait <= 2'd3;
    end else if (cfg_wait != 2'd0) begin
      cfg_wait <= cfg_wait - 2'd1;
    end
  end

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign is_voxel = (in_ch.req_type == REQ_VOXEL) && !all_in;
  assign emit     = is_voxel ? ((TOT_W'(out_index) + TOT_W'(lag)) <= TOT_W'(in_lin)) : all_in;
  assign out_free = !out_vld || out_ch.ready;
  assign last_out = (TOT_W'(out_index) + TOT_W'(1)) >= total;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_xfer && emit) state_next = S_SETUP;
      S_SETUP: state_next = S_OFFS;
      S_OFFS:  state_next = S_READ;
      S_READ:  if (issue_done && !rd_vld) state_next = bin_r ? S_OUT : S_DIV;
      S_DIV:   if (div_done) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the control
  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      S_IDLE:  in_ch.ready = (cfg_wait == 2'd0);
      S_READ: begin
        rd_en     = !issue_done;
        div_start = issue_done && !rd_vld && !bin_r;
      end
      default: ;
    endcase
  end

  assign wr_en = in_xfer && is_voxel;

  // neighbor address, ring of planes
  assign addr_sum = {2'b00, cmod} + {off[OFF_W-1], off};
  always_comb begin
    if (addr_sum[ADDR_W+1]) begin
      addr_fix = addr_sum + (ADDR_W+2)'(STORE_DEPTH);
    end else if (addr_sum >= (ADDR_W+2)'(STORE_DEPTH)) begin
      addr_fix = addr_sum - (ADDR_W+2)'(STORE_DEPTH);
    end else begin
      addr_fix = addr_sum;
    end
  end
  assign rd_addr = addr_fix[ADDR_W-1:0];

  vbm_ram #(.DEPTH(STORE_DEPTH), .WIDTH(PIXEL_BITS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_ch.pixel_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  vbm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (n_cnt),
    .done     (div_done),
    .res      (div_res)
  );

  assign cx_p = {1'b0, cx} + SX_W'(hw_c);
  assign cy_p = {1'b0, cy} + SY_W'(hw_c);
  assign cz_p = {1'b0, cz} + SZ_W'(hw_c);

  assign dx   = cx - xb;
  assign dy   = cy - yb;
  assign dz   = cz - zb;
  assign mz   = OFF_W'(dz[HW_W-1:0]) * OFF_W'(sxsy);
  assign my   = OFF_W'(dy[HW_W-1:0]) * OFF_W'(sx_c);
  assign off0 = '0 - (mz + my + OFF_W'(dx[HW_W-1:0]));

  // round half to even, or majority vote
  assign r2    = {div_res.rem, 1'b0};
  assign q_rnd = div_res.quot + SUM_W'((r2 > {1'b0, n_cnt}) ||
                                       ((r2 == {1'b0, n_cnt}) && div_res.quot[0]));
  assign vote  = ({nz_cnt, 1'b0} > {1'b0, n_cnt}) ? 1'b1 :
                 (({nz_cnt, 1'b0} < {1'b0, n_cnt}) ? 1'b0 : ctr_nz);
  assign res   = bin_r ? PIXEL_BITS'(vote) : q_rnd[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_x       <= '0;
      in_y       <= '0;
      in_z       <= '0;
      in_lin     <= '0;
      wr_addr    <= '0;
      all_in     <= 1'b0;
      out_index  <= '0;
      cx         <= '0;
      cy         <= '0;
      cz         <= '0;
      cmod       <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
      out_vld    <= 1'b0;
      sum        <= '0;
      n_cnt      <= '0;
      nz_cnt     <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      rd_ctr <= (off == '0);
      if (state == S_OUT && out_free) begin
        out_vld <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld <= 1'b0;
      end

      if (cfg_hit) begin
        in_x      <= '0;
        in_y      <= '0;
        in_z      <= '0;
        in_lin    <= '0;
        wr_addr   <= '0;
        all_in    <= 1'b0;
        out_index <= '0;
        cx        <= '0;
        cy        <= '0;
        cz        <= '0;
        cmod      <= '0;
      end

      if (wr_en) begin
        in_lin  <= in_lin + LIN_W'(1);
        wr_addr <= (wr_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_addr + ADDR_W'(1);
        if (({1'b0, in_x} + SX_W'(1)) >= sx_c) begin
          in_x <= '0;
          if (({1'b0, in_y} + SY_W'(1)) >= sy_c) begin
            in_y <= '0;
            if (({1'b0, in_z} + SZ_W'(1)) >= sz_c) begin
              in_z   <= '0;
              all_in <= 1'b1;
            end else begin
              in_z <= in_z + Z_W'(1);
            end
          end else begin
            in_y <= in_y + Y_W'(1);
          end
        end else begin
          in_x <= in_x + X_W'(1);
        end
      end

      if (state == S_SETUP) begin
        xb <= (cx > X_W'(hw_c)) ? cx - X_W'(hw_c) : '0;
        yb <= (cy > Y_W'(hw_c)) ? cy - Y_W'(hw_c) : '0;
        zb <= (cz > Z_W'(hw_c)) ? cz - Z_W'(hw_c) : '0;
        xe <= (cx_p < sx_c) ? cx_p[X_W-1:0] : X_W'(sx_c - SX_W'(1));
        ye <= (cy_p < sy_c) ? cy_p[Y_W-1:0] : Y_W'(sy_c - SY_W'(1));
        ze <= (cz_p < sz_c) ? cz_p[Z_W-1:0] : Z_W'(sz_c - SZ_W'(1));
      end

      if (state == S_OFFS) begin
        off        <= off0;
        row_off    <= off0;
        plane_off  <= off0;
        ix         <= xb;
        iy         <= yb;
        iz         <= zb;
        issue_done <= 1'b0;
        sum        <= '0;
        n_cnt      <= '0;
        nz_cnt     <= '0;
      end

      if (rd_en) begin
        if (ix != xe) begin
          ix  <= ix + X_W'(1);
          off <= off + OFF_W'(1);
        end else if (iy != ye) begin
          ix      <= xb;
          iy      <= iy + Y_W'(1);
          row_off <= row_off + OFF_W'(sx_c);
          off     <= row_off + OFF_W'(sx_c);
        end else if (iz != ze) begin
          ix        <= xb;
          iy        <= yb;
          iz        <= iz + Z_W'(1);
          plane_off <= plane_off + OFF_W'(sxsy);
          row_off   <= plane_off + OFF_W'(sxsy);
          off       <= plane_off + OFF_W'(sxsy);
        end else begin
          issue_done <= 1'b1;
        end
      end

      if (rd_vld) begin
        sum    <= sum + SUM_W'(rd_data);
        n_cnt  <= n_cnt + N_W'(1);
        nz_cnt <= nz_cnt + N_W'(rd_data != '0);
        if (rd_ctr) begin
          ctr_nz <= (rd_data != '0);
        end
      end

      if (state == S_OUT && out_free) begin
        out_pix  <= res;
        out_last <= last_out;
        if (last_out) begin
          in_x      <= '0;
          in_y      <= '0;
          in_z      <= '0;
          in_lin    <= '0;
          wr_addr   <= '0;
          all_in    <= 1'b0;
          out_index <= '0;
          cx        <= '0;
          cy        <= '0;
          cz        <= '0;
          cmod      <= '0;
        end else begin
          out_index <= out_index + LIN_W'(1);
          cmod      <= (cmod == ADDR_W'(STORE_DEPTH - 1)) ? '0 : cmod + ADDR_W'(1);
          if (({1'b0, cx} + SX_W'(1)) >= sx_c) begin
            cx <= '0;
            if (({1'b0, cy} + SY_W'(1)) >= sy_c) begin
              cy <= '0;
              cz <= cz + Z_W'(1);
            end else begin
              cy <= cy + Y_W'(1);
            end
          end else begin
            cx <= cx + X_W'(1);
          end
        end
      end
    end
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.pixel_out  = out_pix;
  assign out_ch.last_voxel = out_last;

  a_rd_from_walk: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == S_READ))
    else $error("ram read data without a cube walk");

  a_cube_count: assert property (@(posedge clk) disable iff (rst)
    n_cnt <= N_W'(CUBE_N) && nz_cnt <= n_cnt)
    else $error("cube voxel count out of range");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (out_vld && state == S_IDLE))
    else $error("result not loaded into output register");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    cmod < ADDR_W'(STORE_DEPTH) && wr_addr < ADDR_W'(STORE_DEPTH))
    else $error("plane store address beyond depth");
endmodule
